// File: rtl/sbbc_pkg.sv
// Shared types and constants for the swept box collision pipeline.
package sbbc_pkg;

  localparam int DIST_W  = 36;
  localparam int VEL_W   = 32;
  localparam int Q_W     = 32;
  localparam int TIME_W  = 34;
  localparam int THR_W   = 16;
  localparam int DIV_LAT = 35;

  localparam logic [THR_W-1:0] STILL_RESET = 16'd655;

  localparam logic signed [1:0] NORM_ZERO = 2'sd0;
  localparam logic signed [1:0] NORM_POS  = 2'sd1;
  localparam logic signed [1:0] NORM_NEG  = -2'sd1;

  typedef struct packed {
    logic signed [DIST_W-1:0] near2;
    logic signed [DIST_W-1:0] far2;
    logic signed [VEL_W-1:0]  vel;
    logic                     still;
  } prep_axis_t;

  typedef struct packed {
    logic still_x;
    logic still_y;
    logic dneg_x;
    logic dneg_y;
  } side_t;

endpackage

// File: rtl/sbbc_prep.sv
// Per-axis entry and exit distances and stillness test, one register stage.
module sbbc_prep
  import sbbc_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [31:0]      mc,
  input  logic        [29:0]      msz,
  input  logic signed [VEL_W-1:0] vel,
  input  logic signed [31:0]      sc,
  input  logic        [29:0]      ssz,
  input  logic        [THR_W-1:0] thr,
  output prep_axis_t              axis_q
);

  logic signed [DIST_W-1:0] gap2;
  logic signed [DIST_W-1:0] sz;
  logic        [VEL_W-1:0]  speed;
  prep_axis_t               axis_next;

  always_comb begin
    gap2  = (DIST_W'(sc) - DIST_W'(mc)) <<< 1;
    sz    = $signed(DIST_W'(ssz) + DIST_W'(msz));
    speed = vel[VEL_W-1] ? VEL_W'(-vel) : VEL_W'(vel);
    axis_next.vel = vel;
    if (vel > 0) begin
      axis_next.near2 = gap2 - sz;
      axis_next.far2  = gap2 + sz;
    end else begin
      axis_next.near2 = gap2 + sz;
      axis_next.far2  = gap2 - sz;
    end
    axis_next.still = (vel == 0) || (speed < {{(VEL_W-THR_W){1'b0}}, thr});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      axis_q <= axis_next;
    end
  end

endmodule

// File: rtl/sbbc_div.sv
// Pipelined signed divider, one quotient bit per stage, saturating to 32 bits.
module sbbc_div
  import sbbc_pkg::*;
#(
  parameter int FRAC_BITS = 16
)
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [DIST_W-1:0] dvd,
  input  logic signed [VEL_W-1:0]  vel,
  output logic signed [Q_W-1:0]    quot
);

  localparam int NUMW = DIST_W + FRAC_BITS - 1;
  localparam int STEPS = Q_W;

  logic signed [NUMW-1:0] num;
  logic        [NUMW-1:0] an;
  logic        [NUMW-1:0] an_q;
  logic        [VEL_W-1:0] av_q;
  logic                   neg_q;

  always_comb begin
    num = NUMW'(dvd) <<< (FRAC_BITS - 1);
    an  = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      an_q  <= an;
      av_q  <= vel[VEL_W-1] ? VEL_W'(-vel) : VEL_W'(vel);
      neg_q <= dvd[DIST_W-1] ^ vel[VEL_W-1];
    end
  end

  logic [VEL_W-1:0] rem_s [0:STEPS];
  logic [Q_W-1:0]   lo_s  [0:STEPS];
  logic [Q_W-1:0]   q_s   [0:STEPS];
  logic [VEL_W-1:0] av_s  [0:STEPS];
  logic             neg_s [0:STEPS];
  logic             ovf_s [0:STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_s[0] <= {{(VEL_W+1+Q_W-NUMW){1'b0}}, an_q[NUMW-1:Q_W]} >= {1'b0, av_q};
      rem_s[0] <= VEL_W'(an_q[NUMW-1:Q_W]);
      lo_s[0]  <= an_q[Q_W-1:0];
      q_s[0]   <= '0;
      av_s[0]  <= av_q;
      neg_s[0] <= neg_q;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [VEL_W:0] rem2;
    logic           ge;
    always_comb begin
      rem2 = {rem_s[k], lo_s[k][Q_W-1]};
      ge   = rem2 >= {1'b0, av_s[k]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1] <= ge ? VEL_W'(rem2 - {1'b0, av_s[k]}) : rem2[VEL_W-1:0];
        lo_s[k+1]  <= lo_s[k] << 1;
        q_s[k+1]   <= {q_s[k][Q_W-2:0], ge};
        av_s[k+1]  <= av_s[k];
        neg_s[k+1] <= neg_s[k];
        ovf_s[k+1] <= ovf_s[k];
      end
    end
  end

  logic [Q_W-1:0] mag;
  logic signed [Q_W-1:0] quot_next;

  always_comb begin
    mag = q_s[STEPS];
    if (!neg_s[STEPS]) begin
      quot_next = (ovf_s[STEPS] || mag[Q_W-1]) ? {1'b0, {(Q_W-1){1'b1}}} : $signed(mag);
    end else if (ovf_s[STEPS] || mag > {1'b1, {(Q_W-1){1'b0}}}) begin
      quot_next = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      quot_next = $signed(-mag);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quot <= quot_next;
    end
  end

endmodule

// File: rtl/sbbc_resolve.sv
// Combines the axis times into hit flag, contact time and face normal.
module sbbc_resolve
  import sbbc_pkg::*;
#(
  parameter int FRAC_BITS = 16
)
(
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [Q_W-1:0] ent_x,
  input  logic signed [Q_W-1:0] ext_x,
  input  logic signed [Q_W-1:0] ent_y,
  input  logic signed [Q_W-1:0] ext_y,
  input  side_t                side,
  output logic                 hit,
  output logic [16:0]          hit_time,
  output logic signed [1:0]    normal_x,
  output logic signed [1:0]    normal_y
);

  localparam logic signed [TIME_W-1:0] INF = TIME_W'(1) <<< Q_W;
  localparam logic signed [TIME_W-1:0] ONE = TIME_W'(1) <<< FRAC_BITS;

  logic signed [TIME_W-1:0] ex, xx, ey, xy, t_in, t_out, t;
  logic        [16:0]       tq;
  logic                     miss;

  always_comb begin
    ex    = side.still_x ? -INF : TIME_W'(ent_x);
    xx    = side.still_x ?  INF : TIME_W'(ext_x);
    ey    = side.still_y ? -INF : TIME_W'(ent_y);
    xy    = side.still_y ?  INF : TIME_W'(ext_y);
    t_in  = (ex > ey) ? ex : ey;
    t_out = (xx < xy) ? xx : xy;
    miss  = (t_in > t_out) || (ex < 0 && ey < 0) || (ex > ONE) || (ey > ONE);
    t     = (t_in < 0) ? '0 : t_in;
  end

  if (FRAC_BITS >= 16) begin : g_down
    assign tq = 17'(t[FRAC_BITS:0] >> (FRAC_BITS - 16));
  end else begin : g_up
    assign tq = 17'(t[FRAC_BITS:0]) << (16 - FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (miss) begin
        hit      <= 1'b0;
        hit_time <= 17'h10000;
        normal_x <= NORM_ZERO;
        normal_y <= NORM_ZERO;
      end else begin
        hit      <= 1'b1;
        hit_time <= tq;
        if (ex > ey) begin
          normal_x <= side.dneg_x ? NORM_POS : NORM_NEG;
          normal_y <= NORM_ZERO;
        end else begin
          normal_x <= NORM_ZERO;
          normal_y <= side.dneg_y ? NORM_POS : NORM_NEG;
        end
      end
    end
  end

endmodule

// File: rtl/swept_box_box_collision.sv
// Top level of the swept box collision pipeline.
// A new query beat is taken every cycle while the output is not stalled; each query passes
// through a pipeline whose depth is set by the bit-per-stage dividers (one register for distances,
// 35 for the four parallel divisions, one for the final compare). The whole pipeline holds
// when a finished result is not taken, so s_axis_tready follows m_axis_tready.
module swept_box_box_collision
  import sbbc_pkg::*;
#(
  parameter int FRAC_BITS = 16
)
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // moving_center_x, moving_center_y, moving_width, moving_height, moving_vel_x,
  // moving_vel_y, static_center_x, static_center_y, static_width, static_height
  input  logic [311:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit_time, normal_x, normal_y, zero padding
  output logic [23:0]  m_axis_tdata,
  // hit
  output logic         m_axis_tuser
);

  localparam int LAST = DIV_LAT + 1;

  logic [THR_W-1:0] thr;
  logic             adv;
  logic [LAST:0]    vld;
  prep_axis_t       px, py;
  side_t            side_d [1:DIV_LAT];
  logic signed [Q_W-1:0] ent_x, ext_x, ent_y, ext_y;
  logic             hit;
  logic [16:0]      hit_time;
  logic signed [1:0] normal_x, normal_y;

  assign adv = !vld[LAST] || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= STILL_RESET;
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:0], s_axis_tvalid};
    end
  end

  sbbc_prep u_prep_x (
    .clk(clk), .en(adv),
    .mc($signed(s_axis_tdata[31:0])), .msz(s_axis_tdata[93:64]),
    .vel($signed(s_axis_tdata[155:124])),
    .sc($signed(s_axis_tdata[219:188])), .ssz(s_axis_tdata[281:252]),
    .thr(thr), .axis_q(px)
  );

  sbbc_prep u_prep_y (
    .clk(clk), .en(adv),
    .mc($signed(s_axis_tdata[63:32])), .msz(s_axis_tdata[123:94]),
    .vel($signed(s_axis_tdata[187:156])),
    .sc($signed(s_axis_tdata[251:220])), .ssz(s_axis_tdata[311:282]),
    .thr(thr), .axis_q(py)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      side_d[1] <= '{still_x: px.still, still_y: py.still,
                     dneg_x: px.near2[DIST_W-1], dneg_y: py.near2[DIST_W-1]};
      for (int k = 2; k <= DIV_LAT; k++) begin
        side_d[k] <= side_d[k-1];
      end
    end
  end

  sbbc_div #(.FRAC_BITS(FRAC_BITS)) u_div_ent_x (
    .clk(clk), .en(adv), .dvd(px.near2), .vel(px.vel), .quot(ent_x));
  sbbc_div #(.FRAC_BITS(FRAC_BITS)) u_div_ext_x (
    .clk(clk), .en(adv), .dvd(px.far2), .vel(px.vel), .quot(ext_x));
  sbbc_div #(.FRAC_BITS(FRAC_BITS)) u_div_ent_y (
    .clk(clk), .en(adv), .dvd(py.near2), .vel(py.vel), .quot(ent_y));
  sbbc_div #(.FRAC_BITS(FRAC_BITS)) u_div_ext_y (
    .clk(clk), .en(adv), .dvd(py.far2), .vel(py.vel), .quot(ext_y));

  sbbc_resolve #(.FRAC_BITS(FRAC_BITS)) u_resolve (
    .clk(clk), .en(adv),
    .ent_x(ent_x), .ext_x(ext_x), .ent_y(ent_y), .ext_y(ext_y),
    .side(side_d[DIV_LAT]),
    .hit(hit), .hit_time(hit_time), .normal_x(normal_x), .normal_y(normal_y)
  );

  assign m_axis_tvalid = vld[LAST];
  assign m_axis_tuser  = hit;
  assign m_axis_tdata  = {3'b000, normal_y, normal_x, hit_time};

endmodule

// File: rtl/sbbc_checker.sv
// Port-level checks for the swept box collision block, bound to the top level.
module sbbc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("Output beat changed while stalled.");

  a_miss: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[16:0] == 17'h10000
      && m_axis_tdata[20:17] == 4'b0000)
    else $error("A miss must report time one and a zero normal.");

  a_hit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[16:0] <= 17'h10000
      && ((m_axis_tdata[18:17] != 2'b00) != (m_axis_tdata[20:19] != 2'b00))
      && m_axis_tdata[18:17] != 2'b10 && m_axis_tdata[20:19] != 2'b10)
    else $error("A hit must report one unit normal and a time within the step.");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("Input stalled without a stalled output.");

endmodule

bind swept_box_box_collision sbbc_checker u_sbbc_checker (
  .clk(clk), .rst(rst), .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
